>>> src/pcsb_pkg.sv
// Shared types and constants for the point-to-scan binner.
package pcsb_pkg;

    localparam int unsigned CORDIC_STEPS = 16;
    localparam logic [15:0] NO_RETURN = 16'hFFFF;
    localparam logic [23:0] ANG_45 = 24'd2949120;
    localparam logic [23:0] ANG_90 = 24'd5898240;
    localparam logic [24:0] ANG_180 = 25'd11796480;

    localparam logic [1:0] REG_HEIGHT = 2'd0;
    localparam logic [1:0] REG_RLOW = 2'd1;
    localparam logic [1:0] REG_RHIGH = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_READ_OUT,
        ST_SQUARE,
        ST_SQRT,
        ST_CORDIC,
        ST_BEARING,
        ST_FETCH,
        ST_UPDATE
    } t_state;

    // Controller commands toward the datapath.
    typedef struct packed {
        logic load;
        logic rd_issue;
        logic rd_clear;
        logic out_load;
        logic sq_load;
        logic sqrt_init;
        logic sqrt_step;
        logic cordic_init;
        logic cordic_step;
        logic bear_load;
        logic fetch;
        logic update;
    } t_cmd;

    // Datapath status toward the controller.
    typedef struct packed {
        logic is_read;
        logic height_ok;
        logic sqrt_done;
        logic range_ok;
        logic cordic_done;
        logic bin_ok;
        logic out_busy;
    } t_status;

    function automatic logic [23:0] atan_step(input logic [3:0] i);
        logic [23:0] v;
        begin
            unique case (i)
                4'd0: v = 24'd2949120;
                4'd1: v = 24'd1740967;
                4'd2: v = 24'd919879;
                4'd3: v = 24'd466945;
                4'd4: v = 24'd234379;
                4'd5: v = 24'd117304;
                4'd6: v = 24'd58666;
                4'd7: v = 24'd29335;
                4'd8: v = 24'd14668;
                4'd9: v = 24'd7334;
                4'd10: v = 24'd3667;
                4'd11: v = 24'd1833;
                4'd12: v = 24'd917;
                4'd13: v = 24'd458;
                4'd14: v = 24'd229;
                default: v = 24'd115;
            endcase
            return v;
        end
    endfunction

endpackage

>>> src/pcsb_if.sv
// Valid/ready channel interfaces for input items and results.
interface pcsb_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [15:0] point_z;
    logic [8:0]  bin_select;
    modport source (output valid, func, point_x, point_y, point_z, bin_select, input ready);
    modport sink (input valid, func, point_x, point_y, point_z, bin_select, output ready);
endinterface

interface pcsb_out_if;
    logic        valid;
    logic        ready;
    logic [8:0]  bin_number;
    logic [15:0] bin_range;
    modport source (output valid, bin_number, bin_range, input ready);
    modport sink (input valid, bin_number, bin_range, output ready);
endinterface

>>> src/point_cloud_to_scan_binner.sv
// Top level of the point-to-scan binner.
// Points (func 0) pass a height gate, a 16-step bit-serial square root for
// the planar range and a 16-step CORDIC for the bearing, then update the
// minimum of their one-degree bin in a single-port RAM. A point gated out by
// height or outside the range window goes back to idle, and one on an axis
// or diagonal skips the CORDIC steps. Read-and-clear items (func 1) return
// one result through an output register; while that register still holds
// an unaccepted result the next read waits for it. After reset a clearing
// pass writes the no-return code to every bin; no transfer is taken then.
// Registers (APB, byte address 4*i): 0 height_limit, 1 range_low,
// 2 range_high; write them only while the block is idle.
module point_cloud_to_scan_binner #(
    parameter int NUM_BINS = 360
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcsb_in_if.sink     in_ch,
    pcsb_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pcsb_pkg::*;

    logic [14:0] r_height;
    logic [15:0] r_rlow, r_rhigh;
    t_cmd    cmd;
    t_status status;
    logic    clear_busy;
    logic    in_ready;

    assign pready = 1'b1;

    // Register writes on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= 15'd100;
            r_rlow <= 16'd100;
            r_rhigh <= 16'd20000;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_HEIGHT: r_height <= pwdata[14:0];
                REG_RLOW: r_rlow <= pwdata[15:0];
                REG_RHIGH: r_rhigh <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_HEIGHT: prdata = {17'd0, r_height};
            REG_RLOW: prdata = {16'd0, r_rlow};
            REG_RHIGH: prdata = {16'd0, r_rhigh};
            default: prdata = '0;
        endcase
    end

    pcsb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_ch.valid),
        .i_clear_busy(clear_busy), .i_status(status),
        .o_in_ready(in_ready), .o_cmd(cmd)
    );
    assign in_ch.ready = in_ready;

    pcsb_dp #(.NUM_BINS(NUM_BINS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_func(in_ch.func), .i_point_x(in_ch.point_x), .i_point_y(in_ch.point_y),
        .i_point_z(in_ch.point_z), .i_bin_select(in_ch.bin_select),
        .i_height_limit(r_height), .i_range_low(r_rlow), .i_range_high(r_rhigh),
        .i_out_ready(out_ch.ready), .o_out_valid(out_ch.valid),
        .o_bin_number(out_ch.bin_number), .o_bin_range(out_ch.bin_range),
        .o_clear_busy(clear_busy), .o_status(status)
    );
endmodule

>>> src/pcsb_ram.sv
// Generic single-port RAM with registered read.
module pcsb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 360
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> src/pcsb_ctrl.sv
// Controller state machine for the binner.
module pcsb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_clear_busy,
    input  pcsb_pkg::t_status  i_status,
    output logic               o_in_ready,
    output pcsb_pkg::t_cmd     o_cmd
);
    import pcsb_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid && !i_clear_busy) n_state = ST_SQUARE;
            ST_SQUARE: begin
                if (i_status.is_read) n_state = ST_READ;
                else if (!i_status.height_ok) n_state = ST_IDLE;
                else n_state = ST_SQRT;
            end
            ST_READ: n_state = ST_READ_OUT;
            ST_READ_OUT: if (!i_status.out_busy) n_state = ST_IDLE;
            ST_SQRT: begin
                if (i_status.sqrt_done) begin
                    n_state = i_status.range_ok ? ST_CORDIC : ST_IDLE;
                end
            end
            ST_CORDIC: if (i_status.cordic_done) n_state = ST_BEARING;
            ST_BEARING: n_state = ST_FETCH;
            ST_FETCH: n_state = i_status.bin_ok ? ST_UPDATE : ST_IDLE;
            ST_UPDATE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = !i_clear_busy;
                o_cmd.load = i_in_valid && !i_clear_busy;
            end
            ST_SQUARE: begin
                o_cmd.sq_load = 1'b1;
                o_cmd.rd_issue = i_status.is_read;
            end
            ST_READ: o_cmd.rd_issue = 1'b1;
            ST_READ_OUT: begin
                // keep the selected bin on the RAM address while the result waits
                o_cmd.rd_issue = 1'b1;
                o_cmd.out_load = !i_status.out_busy;
                o_cmd.rd_clear = !i_status.out_busy;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = !i_status.sqrt_done;
                o_cmd.cordic_init = i_status.sqrt_done;
            end
            ST_CORDIC: o_cmd.cordic_step = !i_status.cordic_done;
            ST_BEARING: o_cmd.bear_load = 1'b1;
            ST_FETCH: o_cmd.fetch = 1'b1;
            ST_UPDATE: o_cmd.update = 1'b1;
            default: ;
        endcase
        o_cmd.sqrt_init = (r_state == ST_SQUARE);
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_update_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |-> $past(r_state) == ST_FETCH) else $error("update w/o fetch");
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear_busy |-> !o_cmd.load) else $error("accept during clear");
`endif
endmodule

>>> src/pcsb_dp.sv
// Datapath: square root, CORDIC bearing, bin store and result register.
module pcsb_dp #(
    parameter int NUM_BINS = 360
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcsb_pkg::t_cmd     i_cmd,
    input  logic               i_func,
    input  logic [15:0]        i_point_x,
    input  logic [15:0]        i_point_y,
    input  logic [15:0]        i_point_z,
    input  logic [8:0]         i_bin_select,
    input  logic [14:0]        i_height_limit,
    input  logic [15:0]        i_range_low,
    input  logic [15:0]        i_range_high,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [8:0]         o_bin_number,
    output logic [15:0]        o_bin_range,
    output logic               o_clear_busy,
    output pcsb_pkg::t_status  o_status
);
    import pcsb_pkg::*;

    localparam int AW = $clog2(NUM_BINS);
    localparam int BW = (AW > 9) ? AW : 9;

    logic        r_func;
    logic [15:0] r_x, r_y;
    logic [15:0] r_az;
    logic [8:0]  r_sel;
    logic [15:0] r_ax, r_ay;
    // root extraction
    logic [31:0] r_rem;
    logic [15:0] r_root;
    logic [4:0]  r_sq_cnt;
    // cordic
    logic signed [34:0] r_cx, r_cy;
    logic signed [25:0] r_cz;
    logic [4:0]  r_cd_cnt;
    logic        r_trivial;
    logic [23:0] r_trivial_ang;
    logic        r_swap;
    logic [BW-1:0] r_bin;
    logic        r_bin_ok;
    // clear pass
    logic        r_clearing;
    logic [AW-1:0] r_clr_addr;
    // output
    logic        r_out_valid;
    logic [8:0]  r_out_num;
    logic [15:0] r_out_rng;
    logic        sel_ok;

    logic [15:0] abs_x, abs_y, abs_z;
    assign abs_x = i_point_x[15] ? 16'(-i_point_x) : i_point_x;
    assign abs_y = i_point_y[15] ? 16'(-i_point_y) : i_point_y;
    assign abs_z = i_point_z[15] ? 16'(-i_point_z) : i_point_z;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_x <= i_point_x;
            r_y <= i_point_y;
            r_az <= abs_z;
            r_sel <= i_bin_select;
            r_ax <= abs_x;
            r_ay <= abs_y;
        end
    end

    // Restoring square root, one result bit per cycle.
    logic [31:0] sq_sum;
    logic [17:0] trial;
    assign sq_sum = 32'(r_ax * r_ax) + 32'(r_ay * r_ay);
    logic [33:0] r_acc;
    assign trial = {r_root, 2'b01};
    logic [33:0] sh_acc;
    assign sh_acc = {r_acc[31:0], r_rem[31:30]};
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_rem <= sq_sum;
            r_root <= '0;
            r_acc <= '0;
            r_sq_cnt <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rem <= {r_rem[29:0], 2'b00};
            if (sh_acc >= 34'(trial)) begin
                r_acc <= sh_acc - 34'(trial);
                r_root <= {r_root[14:0], 1'b1};
            end else begin
                r_acc <= sh_acc;
                r_root <= {r_root[14:0], 1'b0};
            end
            r_sq_cnt <= r_sq_cnt + 5'd1;
        end
    end

    // CORDIC vectoring on the octant, one step per cycle.
    logic [15:0] hi_v, lo_v;
    assign hi_v = (r_ay > r_ax) ? r_ay : r_ax;
    assign lo_v = (r_ay > r_ax) ? r_ax : r_ay;
    logic signed [34:0] dx, dy, neg_cy;
    assign neg_cy = -r_cy;
    assign dx = r_cy[34] ? -(neg_cy >>> r_cd_cnt[3:0]) : (r_cy >>> r_cd_cnt[3:0]);
    assign dy = r_cx >>> r_cd_cnt[3:0];
    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_init) begin
            r_cx <= 35'({hi_v, 16'h0});
            r_cy <= 35'({lo_v, 16'h0});
            r_cz <= '0;
            r_cd_cnt <= '0;
            r_swap <= r_ay > r_ax;
            r_trivial <= (lo_v == 16'd0) || (lo_v == hi_v);
            r_trivial_ang <= (lo_v == 16'd0) ? 24'd0 : ANG_45;
        end else if (i_cmd.cordic_step) begin
            if (!r_cy[34]) begin
                r_cx <= r_cx + dx;
                r_cy <= r_cy - dy;
                r_cz <= r_cz + 26'(atan_step(r_cd_cnt[3:0]));
            end else begin
                r_cx <= r_cx - dx;
                r_cy <= r_cy + dy;
                r_cz <= r_cz - 26'(atan_step(r_cd_cnt[3:0]));
            end
            r_cd_cnt <= r_cd_cnt + 5'd1;
        end
    end

    // Quadrant fold and bin index.
    logic [23:0] oct, t_ang;
    logic signed [26:0] a_ang, u_ang;
    always_comb begin
        if (r_trivial) oct = r_trivial_ang;
        else if (r_cz[25]) oct = '0;
        else if (r_cz > 26'(ANG_45)) oct = ANG_45;
        else oct = r_cz[23:0];
        t_ang = r_swap ? ANG_90 - oct : oct;
        if (!r_x[15]) a_ang = r_y[15] ? -27'(t_ang) : 27'(t_ang);
        else a_ang = r_y[15] ? -(27'(ANG_180) - 27'(t_ang)) : 27'(ANG_180) - 27'(t_ang);
        u_ang = a_ang + 27'(ANG_180);
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.bear_load) begin
            r_bin <= BW'(u_ang[25:16]);
            r_bin_ok <= !u_ang[26] && (32'(u_ang[25:16]) < 32'(NUM_BINS));
        end
    end

    // Bin store.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0]   ram_wdata, ram_rdata;
    always_comb begin
        ram_we = 1'b0;
        ram_addr = r_bin[AW-1:0];
        ram_wdata = r_root;
        if (r_clearing) begin
            ram_we = 1'b1;
            ram_addr = r_clr_addr;
            ram_wdata = NO_RETURN;
        end else if (i_cmd.rd_issue || i_cmd.rd_clear) begin
            ram_addr = AW'(r_sel);
            ram_we = i_cmd.rd_clear && sel_ok;
            ram_wdata = NO_RETURN;
        end else if (i_cmd.update) begin
            ram_we = r_root < ram_rdata;
        end
    end
    pcsb_ram #(.WIDTH(16), .DEPTH(NUM_BINS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );
    assign sel_ok = 32'(r_sel) < 32'(NUM_BINS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (32'(r_clr_addr) == NUM_BINS - 1) r_clearing <= 1'b0;
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_num <= r_sel;
            r_out_rng <= sel_ok ? ram_rdata : NO_RETURN;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bin_number = r_out_num;
    assign o_bin_range = r_out_rng;
    assign o_clear_busy = r_clearing;

    always_comb begin
        o_status.is_read = r_func;
        o_status.height_ok = r_az <= {1'b0, i_height_limit};
        o_status.sqrt_done = r_sq_cnt == 5'd16;
        o_status.range_ok = (r_root >= i_range_low) && (r_root <= i_range_high);
        o_status.cordic_done = r_trivial || r_cd_cnt == 5'(CORDIC_STEPS);
        o_status.bin_ok = r_bin_ok;
        o_status.out_busy = r_out_valid && !i_out_ready;
    end

`ifndef SYNTHESIS
    a_clear_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_cmd.update) else $error("update during clear");
    a_sqrt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqrt_step |-> r_sq_cnt < 5'd16) else $error("sqrt overrun");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_out_rng)) else $error("out changed");
`endif
endmodule

>>> sim/tb_point_cloud_to_scan_binner.sv
// Regression of the point-to-scan binner: points and bin reads with a local predictor.
module tb_point_cloud_to_scan_binner;
    import pcsb_pkg::*;

    localparam int NUM_BINS = 360;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    pcsb_in_if in_ch ();
    pcsb_out_if out_ch ();

    point_cloud_to_scan_binner #(.NUM_BINS(NUM_BINS)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    typedef struct packed {
        logic [8:0] bin_number;
        logic [15:0] bin_range;
    } t_bin_read;

    // Predictor state: a mirror of the bin store and the registers.
    logic [15:0] scan_mirror [NUM_BINS];
    logic [14:0] mir_height;
    logic [15:0] mir_rlow;
    logic [15:0] mir_rhigh;
    // Expected results, indexed by a running head and tail count.
    t_bin_read pending_reads [int];
    int exp_head;
    int exp_tail;

    int errors;
    int idle_cycles;
    bit stall_hold;
    int stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Floor square root, bit by bit.
    function automatic logic [31:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 32;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root[31:0];
    endfunction

    function automatic longint trunc_shift(input longint v, input int s);
        return v >= 0 ? (v >>> s) : -((-v) >>> s);
    endfunction

    function automatic longint atan_entry(input int i);
        longint tbl [16];
        tbl = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return tbl[i];
    endfunction

    // Octant angle in Q16 degrees, 0 <= lo <= hi.
    function automatic longint octant_q16(input longint hi, input longint lo);
        longint cx, cy, za, dx, dy;
        if (lo == 0) return 0;
        if (lo == hi) return longint'(ANG_45);
        cx = hi * 65536;
        cy = lo * 65536;
        za = 0;
        for (int i = 0; i < 16; i++) begin
            dx = trunc_shift(cy, i);
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx; cy -= dy; za += atan_entry(i);
            end else begin
                cx -= dx; cy += dy; za -= atan_entry(i);
            end
        end
        if (za < 0) za = 0;
        if (za > longint'(ANG_45)) za = longint'(ANG_45);
        return za;
    endfunction

    // Fold one point into the mirror.
    task automatic predict_point(input logic [15:0] px, input logic [15:0] py,
                                 input logic [15:0] pz);
        longint x, y, z, ax, ay, az, t, a, u, rng, bn;
        x = longint'($signed(px));
        y = longint'($signed(py));
        z = longint'($signed(pz));
        az = z < 0 ? -z : z;
        if (az > longint'(mir_height)) return;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        rng = floor_root(64'(ax * ax + ay * ay));
        if (rng < longint'(mir_rlow) || rng > longint'(mir_rhigh)) return;
        if (ay > ax) t = longint'(ANG_90) - octant_q16(ay, ax);
        else t = octant_q16(ax, ay);
        if (x >= 0) a = (y >= 0) ? t : -t;
        else a = (y >= 0) ? (longint'(ANG_180) - t) : -(longint'(ANG_180) - t);
        u = a + longint'(ANG_180);
        if (u < 0) u = 0;
        bn = u >>> 16;
        if (bn >= NUM_BINS) return;
        if (rng < longint'(scan_mirror[bn])) scan_mirror[bn] = rng[15:0];
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic enqueue_read(input t_bin_read r);
        pending_reads[exp_tail] = r;
        exp_tail++;
    endtask

    // Source one item: random pre-gap in bursts, wait for the transfer.
    // Valid stays high after the transfer; the next item or wait_quiet drops it.
    task automatic send_item(input logic f, input logic [15:0] px, input logic [15:0] py,
                             input logic [15:0] pz, input logic [8:0] sel, input bit gaps);
        t_bin_read r;
        if (gaps && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= f;
        in_ch.point_x <= px;
        in_ch.point_y <= py;
        in_ch.point_z <= pz;
        in_ch.bin_select <= sel;
        do @(posedge i_clk); while (!in_ch.ready);
        // predict at the transfer edge
        if (f == FUNC_READ) begin
            r.bin_number = sel;
            if (sel < NUM_BINS) begin
                r.bin_range = scan_mirror[sel];
                scan_mirror[sel] = NO_RETURN;
            end else begin
                r.bin_range = NO_RETURN;
            end
            enqueue_read(r);
        end else begin
            predict_point(px, py, pz);
        end
    endtask

    task automatic add_point(input logic [15:0] px, input logic [15:0] py,
                             input logic [15:0] pz, input bit gaps);
        send_item(FUNC_ADD, px, py, pz, 9'($urandom), gaps);
    endtask

    task automatic read_bin(input logic [8:0] sel, input bit gaps);
        send_item(FUNC_READ, 16'($urandom), 16'($urandom), 16'($urandom), sel, gaps);
    endtask

    // Drain results, then hold off past the point latency before idling.
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (exp_tail != exp_head) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // return the bus to idle between writes
        @(posedge i_clk);
        case (idx)
            REG_HEIGHT: mir_height = val[14:0];
            REG_RLOW: mir_rlow = val[15:0];
            default: mir_rhigh = val[15:0];
        endcase
    endtask

    task automatic set_window(input logic [31:0] h, input logic [31:0] lo,
                              input logic [31:0] hi);
        wait_quiet();
        write_reg(REG_HEIGHT, h);
        write_reg(REG_RLOW, lo);
        write_reg(REG_RHIGH, hi);
    endtask

    task automatic sweep_all_bins(input bit gaps);
        for (int b = 0; b < NUM_BINS; b++) read_bin(9'(b), gaps);
    endtask

    // Edge cases: origin, axes, diagonals, -x axis, z extremes, empty window.
    task automatic test_directed();
        set_window(32'd32767, 32'd0, 32'd46341);
        add_point(16'd0, 16'd0, 16'd0, 0);
        add_point(16'h7FFF, 16'd0, 16'h7FFF, 0);
        add_point(16'h8000, 16'd0, 16'd0, 0);
        add_point(16'd0, 16'h8000, 16'd0, 0);
        add_point(16'd0, 16'h7FFF, 16'd0, 0);
        add_point(16'h8000, 16'h8000, 16'd0, 0);
        add_point(16'd500, 16'd500, 16'h8001, 0);
        add_point(16'd3, 16'd1, 16'h8000, 0);
        add_point(-16'sd700, 16'd1, 16'd0, 0);
        add_point(16'd1000, -16'sd1, 16'd0, 0);
        read_bin(9'd180, 0);
        read_bin(9'd0, 0);
        read_bin(9'd90, 0);
        read_bin(9'd270, 0);
        read_bin(9'd359, 0);
        read_bin(9'd45, 0);
        read_bin(9'd511, 0);
        read_bin(9'd360, 0);
        set_window(32'd0, 32'd5000, 32'd10);
        add_point(16'd2000, 16'd2000, 16'd0, 0);
        read_bin(9'd225, 0);
    endtask

    // Random points in a window, mostly kept, with reads mixed in.
    task automatic test_random(input int count, input int zmax);
        logic [15:0] px, py, pz;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 4) == 0) begin
                read_bin(9'($urandom_range(0, 8) == 0 ? $urandom_range(360, 511)
                                                       : $urandom_range(0, 359)), 1);
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    px = 16'($urandom); py = 16'($urandom); pz = 16'($urandom);
                end else begin
                    px = 16'($signed($urandom_range(0, 4000)) - 2000);
                    py = 16'($signed($urandom_range(0, 4000)) - 2000);
                    pz = 16'($signed($urandom_range(0, 2 * zmax)) - zmax);
                end
                add_point(px, py, pz, 1);
            end
        end
    endtask

    // Hold the receiver off a long stretch while reads queue up.
    task automatic test_backpressure();
        stall_hold = 1'b1;
        for (int n = 0; n < 12; n++) read_bin(9'($urandom_range(0, 359)), 0);
        wait_quiet();
    endtask

    // Receiver: its own stall pattern, plus a counted long hold.
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_hold) begin
                out_ch.ready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= 400) begin
                    stall_hold = 1'b0;
                    hold_cnt = 0;
                end
            end else if (stall_mode == 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Result checker against the oldest expectation.
    initial begin
        t_bin_read want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (exp_tail == exp_head) begin
                    report_mismatch("unexpected result bin", out_ch.bin_number, -1);
                end else begin
                    want = pending_reads[exp_head];
                    pending_reads.delete(exp_head);
                    exp_head++;
                    if (out_ch.bin_number !== want.bin_number)
                        report_mismatch("bin_number", out_ch.bin_number, want.bin_number);
                    if (out_ch.bin_range !== want.bin_range)
                        report_mismatch("bin_range", out_ch.bin_range, want.bin_range);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer (covers the clearing pass).
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("point_cloud_to_scan_binner regression: fail");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        exp_head = 0;
        exp_tail = 0;
        stall_hold = 1'b0;
        stall_mode = 0;
        for (int b = 0; b < NUM_BINS; b++) scan_mirror[b] = NO_RETURN;
        mir_height = 15'd100;
        mir_rlow = 16'd100;
        mir_rhigh = 16'd20000;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.func <= FUNC_ADD;
        in_ch.point_x <= '0;
        in_ch.point_y <= '0;
        in_ch.point_z <= '0;
        in_ch.bin_select <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        stall_mode = 1;
        set_window(32'd100, 32'd100, 32'd20000);
        test_random(400, 150);
        test_backpressure();
        stall_mode = 0;
        set_window(32'd32767, 32'd0, 32'd46341);
        test_random(400, 30000);
        sweep_all_bins(1);
        stall_mode = 1;
        set_window(32'd0, 32'd0, 32'd0);
        test_random(100, 2);
        set_window(32'd2000, 32'd1500, 32'd1600);
        test_random(300, 3000);
        sweep_all_bins(1);
        wait_quiet();

        if (errors == 0)
            $display("point_cloud_to_scan_binner regression: pass");
        else
            $display("point_cloud_to_scan_binner regression: fail");
        $finish;
    end
endmodule
